@@ rtl/gamepad_input_conditioner_assert.svh @@
// Assertion macros for the gamepad input conditioner.
`ifndef GAMEPAD_INPUT_CONDITIONER_ASSERT_SVH
`define GAMEPAD_INPUT_CONDITIONER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define GIC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gamepad_input_conditioner: assertion failed");
// next-cycle implication
`define GIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gamepad_input_conditioner: assertion failed");
`else
`define GIC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define GIC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/gic_pkg.sv @@
// Shared types, constants and codes for the gamepad input conditioner.
package gic_pkg;

    localparam int AXIS_W = 16;
    localparam int DZ_W   = 15;
    localparam int TRIG_W = 8;
    localparam int BTN_W  = 16;

    localparam logic [BTN_W-1:0]  BUTTON_USED_MASK = 16'hF3FF;
    localparam logic [DZ_W-1:0]   AXIS_FULL        = 15'd32767;
    localparam logic [TRIG_W-1:0] TRIG_RAW_MAX     = 8'd255;

    localparam logic [DZ_W-1:0]   LEFT_DZ_RESET  = 15'd7849;
    localparam logic [DZ_W-1:0]   RIGHT_DZ_RESET = 15'd8689;
    localparam logic [TRIG_W-1:0] TRIG_TH_RESET  = 8'd30;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_TH  = 2'd2;

    // shared multiplier
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // shift-subtract unit: 16-step divide or 24-step square root
    localparam int ITER_A_W   = 56;
    localparam int ITER_B_W   = 40;
    localparam int ITER_REM_W = ITER_B_W + 1;
    localparam int ITER_SRC_W = 48;
    localparam int ITER_Q_W   = 24;
    localparam int ITER_DIV_LO = ITER_A_W - ITER_B_W;
    localparam int ITER_CNT_W = 5;
    localparam logic [ITER_CNT_W-1:0] DIV_STEPS  = 5'd16;
    localparam logic [ITER_CNT_W-1:0] SQRT_STEPS = 5'd24;

    typedef struct packed {
        logic start;
        logic mode_sqrt;
    } gic_iter_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } gic_iter_sts_t;

    typedef struct packed {
        logic                     poll_ok;
        logic signed [AXIS_W-1:0] left_stick_x;
        logic signed [AXIS_W-1:0] left_stick_y;
        logic signed [AXIS_W-1:0] right_stick_x;
        logic signed [AXIS_W-1:0] right_stick_y;
        logic [TRIG_W-1:0]        left_trigger;
        logic [TRIG_W-1:0]        right_trigger;
        logic [BTN_W-1:0]         button_word;
    } gic_in_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] left_stick_x_out;
        logic signed [AXIS_W-1:0] left_stick_y_out;
        logic signed [AXIS_W-1:0] right_stick_x_out;
        logic signed [AXIS_W-1:0] right_stick_y_out;
        logic [15:0]              left_trigger_out;
        logic [15:0]              right_trigger_out;
        logic [BTN_W-1:0]         buttons_pressed;
        logic [BTN_W-1:0]         buttons_released;
        logic [BTN_W-1:0]         buttons_held;
        logic                     is_connected;
        logic                     connect_event;
        logic                     disconnect_event;
    } gic_out_t;

endpackage

@@ rtl/gic_mul.sv @@
// Registered unsigned multiplier shared by all product steps.
module gic_mul (
    input  logic                         clk,
    input  logic [gic_pkg::MUL_A_W-1:0]  mul_a,
    input  logic [gic_pkg::MUL_B_W-1:0]  mul_b,
    output logic [gic_pkg::MUL_P_W-1:0]  product
);
    import gic_pkg::*;

    logic [MUL_P_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    assign product = product_reg;

endmodule

@@ rtl/gic_iter_unit.sv @@
// Shift-subtract unit: restoring divide (16 quotient bits) or integer square root (24 bits).
`include "gamepad_input_conditioner_assert.svh"

module gic_iter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gic_pkg::gic_iter_ctl_t        ctl,
    input  logic [gic_pkg::ITER_A_W-1:0]  op_a,
    input  logic [gic_pkg::ITER_B_W-1:0]  op_b,
    output gic_pkg::gic_iter_sts_t        sts,
    output logic [gic_pkg::ITER_Q_W-1:0]  result
);
    import gic_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic                    mode_reg, mode_next;
    logic [ITER_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ITER_REM_W-1:0]   rem_reg, rem_next;
    logic [ITER_SRC_W-1:0]   src_reg, src_next;
    logic [ITER_Q_W-1:0]     q_reg, q_next;
    logic [ITER_B_W-1:0]     div_reg, div_next;

    logic [ITER_REM_W-1:0]   shifted;
    logic [ITER_REM_W-1:0]   trial;
    logic [ITER_REM_W:0]     diff;
    logic                    ge;

    // one step: bring in the next digit, try the subtract
    always_comb
    begin
        if (mode_reg)
        begin
            shifted = {rem_reg[ITER_REM_W-3:0], src_reg[ITER_SRC_W-1 -: 2]};
            trial   = {{(ITER_REM_W-ITER_Q_W-2){1'b0}}, q_reg, 2'b01};
        end
        else
        begin
            shifted = {rem_reg[ITER_REM_W-2:0], src_reg[ITER_SRC_W-1]};
            trial   = {1'b0, div_reg};
        end
        diff = {1'b0, shifted} - {1'b0, trial};
        ge   = !diff[ITER_REM_W];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        src_next  = src_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            mode_next = ctl.mode_sqrt;
            q_next    = '0;
            div_next  = op_b;
            if (ctl.mode_sqrt)
            begin
                cnt_next = SQRT_STEPS;
                rem_next = '0;
                src_next = op_a[ITER_SRC_W-1:0];
            end
            else
            begin
                cnt_next = DIV_STEPS;
                rem_next = {1'b0, op_a[ITER_A_W-1:ITER_DIV_LO]};
                src_next = {op_a[ITER_DIV_LO-1:0], {(ITER_SRC_W-ITER_DIV_LO){1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[ITER_REM_W-1:0] : shifted;
            q_next   = {q_reg[ITER_Q_W-2:0], ge};
            src_next = mode_reg ? {src_reg[ITER_SRC_W-3:0], 2'b00}
                                : {src_reg[ITER_SRC_W-2:0], 1'b0};
            cnt_next = cnt_reg - ITER_CNT_W'(1);
            if (cnt_reg == ITER_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        src_reg <= src_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = q_reg;

    `GIC_ASSERT_IMPLIES(a_no_restart, clk, rst_n, ctl.start, !busy_reg)
    `GIC_ASSERT_NEXT(a_last_step_done, clk, rst_n, busy_reg && (cnt_reg == ITER_CNT_W'(1)), done_reg && !busy_reg)
    `GIC_ASSERT_IMPLIES(a_done_when_idle, clk, rst_n, done_reg, !busy_reg)

endmodule

@@ rtl/gamepad_input_conditioner.sv @@
// A failed poll goes straight to the output stage; a good poll with both sticks inside their
// dead zones and both triggers off runs no square root and no divide.
// The long path is the 24-step square root per stick and a 16-step divide per stick axis and
// per trigger, run one after another on the single shift-subtract unit.
// One request at a time: in_ready rises again once the result is registered, later while a result waits.
// Reset (rst_n, async, low): dead zones to defaults, held values, button mask, presence cleared.
`include "gamepad_input_conditioner_assert.svh"

module gamepad_input_conditioner (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  gic_pkg::gic_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output gic_pkg::gic_out_t                out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gic_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gic_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MX     = 4'd1;
    localparam logic [3:0] ST_MY     = 4'd2;
    localparam logic [3:0] ST_MD     = 4'd3;
    localparam logic [3:0] ST_CMP    = 4'd4;
    localparam logic [3:0] ST_SQRT   = 4'd5;
    localparam logic [3:0] ST_AX     = 4'd6;
    localparam logic [3:0] ST_MDEN   = 4'd7;
    localparam logic [3:0] ST_DSTART = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_TRIG   = 4'd10;
    localparam logic [3:0] ST_TDIV   = 4'd11;
    localparam logic [3:0] ST_DONE   = 4'd12;

    // control
    logic [3:0]          state_reg, state_next;
    logic                stick_reg, stick_next;
    logic                axis_reg, axis_next;
    logic                trig_sel_reg, trig_sel_next;
    logic                out_valid_reg, out_valid_next;

    // configuration
    logic [DZ_W-1:0]     left_dz_reg, right_dz_reg;
    logic [TRIG_W-1:0]   trig_th_reg;

    // conditioner state
    logic [AXIS_W-1:0]   axis_hold_reg [4];
    logic [AXIS_W-1:0]   axis_hold_next [4];
    logic [15:0]         trig_hold_reg [2];
    logic [15:0]         trig_hold_next [2];
    logic [BTN_W-1:0]    held_mask_reg, held_mask_next;
    logic                present_reg, present_next;

    // payload
    gic_in_t             in_reg, in_next;
    gic_out_t            out_reg, out_next;
    logic [30:0]         acc_reg, acc_next;
    logic [ITER_Q_W-1:0] root_reg, root_next;
    logic [MUL_P_W-1:0]  num_reg, num_next;

    // datapath
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  product;
    gic_iter_ctl_t       iter_ctl;
    gic_iter_sts_t       iter_sts;
    logic [ITER_A_W-1:0] iter_a;
    logic [ITER_B_W-1:0] iter_b;
    logic [ITER_Q_W-1:0] iter_result;

    logic [AXIS_W-1:0]   sel_raw;
    logic                sel_neg;
    logic [AXIS_W-1:0]   sel_abs;
    logic [DZ_W-1:0]     mag;
    logic [DZ_W-1:0]     dz;
    logic [DZ_W-1:0]     dz_span;
    logic                dz_full;
    logic [29:0]         mag_scaled;
    logic [ITER_Q_W-1:0] r_off;
    logic                inside_dz;
    logic [1:0]          hold_idx;
    logic [DZ_W-1:0]     q_mag;
    logic [AXIS_W-1:0]   axis_result;
    logic [AXIS_W-1:0]   axis_full_signed;

    logic [TRIG_W-1:0]   trig_raw;
    logic                trig_zero;
    logic [TRIG_W-1:0]   trig_diff;
    logic [TRIG_W-1:0]   trig_den;
    logic [23:0]         trig_num;
    logic [BTN_W-1:0]    buttons_now;

    gic_mul u_mul (
        .clk     (clk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (product)
    );

    gic_iter_unit u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (iter_ctl),
        .op_a   (iter_a),
        .op_b   (iter_b),
        .sts    (iter_sts),
        .result (iter_result)
    );

    // axis selected by stick and axis pointers; -32768 folds to -32767
    always_comb
    begin
        hold_idx = {stick_reg, axis_reg};
        unique case (hold_idx)
            2'b00:   sel_raw = in_reg.left_stick_x;
            2'b01:   sel_raw = in_reg.left_stick_y;
            2'b10:   sel_raw = in_reg.right_stick_x;
            default: sel_raw = in_reg.right_stick_y;
        endcase
        sel_neg = sel_raw[AXIS_W-1];
        sel_abs = sel_neg ? (AXIS_W'(0) - sel_raw) : sel_raw;
        mag     = sel_abs[AXIS_W-1] ? AXIS_FULL : sel_abs[DZ_W-1:0];

        dz         = stick_reg ? right_dz_reg : left_dz_reg;
        dz_full    = (dz == AXIS_FULL);
        dz_span    = AXIS_FULL - dz;
        mag_scaled = {mag, 15'd0} - {15'd0, mag};
        r_off      = root_reg - {1'b0, dz, 8'd0};
        inside_dz  = ({1'b0, acc_reg} <= product[31:0]);

        // quotient bit 15 set means the true result is past full scale
        q_mag            = iter_result[15] ? AXIS_FULL : iter_result[DZ_W-1:0];
        axis_result      = sel_neg ? (AXIS_W'(0) - {1'b0, q_mag}) : {1'b0, q_mag};
        axis_full_signed = sel_neg ? (AXIS_W'(0) - {1'b0, AXIS_FULL}) : {1'b0, AXIS_FULL};

        trig_raw  = trig_sel_reg ? in_reg.right_trigger : in_reg.left_trigger;
        trig_zero = (trig_raw <= trig_th_reg);
        trig_diff = trig_raw - trig_th_reg;
        trig_den  = TRIG_RAW_MAX - trig_th_reg;
        trig_num  = {trig_diff, 16'd0} - {16'd0, trig_diff} + {17'd0, trig_den[TRIG_W-1:1]};

        buttons_now = in_reg.button_word & BUTTON_USED_MASK;
    end

    // shared unit operands
    always_comb
    begin
        unique case (state_reg)
            ST_MX, ST_MY:
            begin
                mul_a = {17'd0, mag};
                mul_b = {9'd0, mag};
            end
            ST_MD:
            begin
                mul_a = {17'd0, dz};
                mul_b = {9'd0, dz};
            end
            ST_AX:
            begin
                mul_a = {2'd0, mag_scaled};
                mul_b = r_off;
            end
            ST_MDEN:
            begin
                mul_a = {8'd0, root_reg};
                mul_b = {9'd0, dz_span};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        iter_ctl.mode_sqrt = (state_reg == ST_CMP);
        iter_ctl.start     = ((state_reg == ST_CMP) && !inside_dz)
                             || (state_reg == ST_DSTART)
                             || ((state_reg == ST_TRIG) && !trig_zero);
        unique case (state_reg)
            ST_CMP:
            begin
                iter_a = {9'd0, acc_reg, 16'd0};
                iter_b = '0;
            end
            ST_DSTART:
            begin
                // rounding: numerator plus half the denominator
                iter_a = num_reg + {1'b0, product[MUL_P_W-1:1]};
                iter_b = product[ITER_B_W-1:0];
            end
            ST_TRIG:
            begin
                iter_a = {32'd0, trig_num};
                iter_b = {32'd0, trig_den};
            end
            default:
            begin
                iter_a = '0;
                iter_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        stick_next     = stick_reg;
        axis_next      = axis_reg;
        trig_sel_next  = trig_sel_reg;
        out_valid_next = out_valid_reg;
        in_next        = in_reg;
        out_next       = out_reg;
        acc_next       = acc_reg;
        root_next      = root_reg;
        num_next       = num_reg;
        held_mask_next = held_mask_reg;
        present_next   = present_reg;
        for (int i = 0; i < 4; i++)
        begin
            axis_hold_next[i] = axis_hold_reg[i];
        end
        for (int i = 0; i < 2; i++)
        begin
            trig_hold_next[i] = trig_hold_reg[i];
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_next       = in_data;
                    stick_next    = 1'b0;
                    axis_next     = 1'b0;
                    trig_sel_next = 1'b0;
                    state_next    = in_data.poll_ok ? ST_MX : ST_DONE;
                end
            end
            ST_MX:
            begin
                axis_next  = 1'b1;
                state_next = ST_MY;
            end
            ST_MY:
            begin
                acc_next   = product[30:0];
                axis_next  = 1'b0;
                state_next = ST_MD;
            end
            ST_MD:
            begin
                acc_next   = acc_reg + product[30:0];
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (inside_dz)
                begin
                    axis_hold_next[{stick_reg, 1'b0}] = '0;
                    axis_hold_next[{stick_reg, 1'b1}] = '0;
                    if (!stick_reg)
                    begin
                        stick_next = 1'b1;
                        state_next = ST_MX;
                    end
                    else
                    begin
                        state_next = ST_TRIG;
                    end
                end
                else
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (iter_sts.done)
                begin
                    root_next  = iter_result;
                    state_next = ST_AX;
                end
            end
            ST_AX:
            begin
                if ((mag == '0) || dz_full)
                begin
                    axis_hold_next[hold_idx] = (mag == '0) ? '0 : axis_full_signed;
                    if (!axis_reg)
                    begin
                        axis_next = 1'b1;
                    end
                    else if (!stick_reg)
                    begin
                        stick_next = 1'b1;
                        axis_next  = 1'b0;
                        state_next = ST_MX;
                    end
                    else
                    begin
                        state_next = ST_TRIG;
                    end
                end
                else
                begin
                    state_next = ST_MDEN;
                end
            end
            ST_MDEN:
            begin
                num_next   = product;
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (iter_sts.done)
                begin
                    axis_hold_next[hold_idx] = axis_result;
                    if (!axis_reg)
                    begin
                        axis_next  = 1'b1;
                        state_next = ST_AX;
                    end
                    else if (!stick_reg)
                    begin
                        stick_next = 1'b1;
                        axis_next  = 1'b0;
                        state_next = ST_MX;
                    end
                    else
                    begin
                        state_next = ST_TRIG;
                    end
                end
            end
            ST_TRIG:
            begin
                if (trig_zero)
                begin
                    trig_hold_next[trig_sel_reg] = '0;
                    if (!trig_sel_reg)
                    begin
                        trig_sel_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV:
            begin
                if (iter_sts.done)
                begin
                    trig_hold_next[trig_sel_reg] = iter_result[15:0];
                    if (!trig_sel_reg)
                    begin
                        trig_sel_next = 1'b1;
                        state_next    = ST_TRIG;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.left_stick_x_out  = axis_hold_reg[0];
                    out_next.left_stick_y_out  = axis_hold_reg[1];
                    out_next.right_stick_x_out = axis_hold_reg[2];
                    out_next.right_stick_y_out = axis_hold_reg[3];
                    out_next.left_trigger_out  = trig_hold_reg[0];
                    out_next.right_trigger_out = trig_hold_reg[1];
                    if (in_reg.poll_ok)
                    begin
                        out_next.buttons_pressed  = buttons_now & ~held_mask_reg;
                        out_next.buttons_released = held_mask_reg & ~buttons_now;
                        held_mask_next            = buttons_now;
                    end
                    else
                    begin
                        out_next.buttons_pressed  = '0;
                        out_next.buttons_released = '0;
                    end
                    out_next.buttons_held     = in_reg.poll_ok ? buttons_now : held_mask_reg;
                    out_next.is_connected     = in_reg.poll_ok;
                    out_next.connect_event    = in_reg.poll_ok && !present_reg;
                    out_next.disconnect_event = !in_reg.poll_ok && present_reg;
                    present_next              = in_reg.poll_ok;
                    out_valid_next            = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stick_reg     <= 1'b0;
            axis_reg      <= 1'b0;
            trig_sel_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_mask_reg <= '0;
            present_reg   <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                axis_hold_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++)
            begin
                trig_hold_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            stick_reg     <= stick_next;
            axis_reg      <= axis_next;
            trig_sel_reg  <= trig_sel_next;
            out_valid_reg <= out_valid_next;
            held_mask_reg <= held_mask_next;
            present_reg   <= present_next;
            for (int i = 0; i < 4; i++)
            begin
                axis_hold_reg[i] <= axis_hold_next[i];
            end
            for (int i = 0; i < 2; i++)
            begin
                trig_hold_reg[i] <= trig_hold_next[i];
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_dz_reg  <= LEFT_DZ_RESET;
            right_dz_reg <= RIGHT_DZ_RESET;
            trig_th_reg  <= TRIG_TH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LEFT_DZ:  left_dz_reg  <= cfg_data[DZ_W-1:0];
                CFG_RIGHT_DZ: right_dz_reg <= cfg_data[DZ_W-1:0];
                CFG_TRIG_TH:  trig_th_reg  <= cfg_data[TRIG_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        out_reg  <= out_next;
        acc_reg  <= acc_next;
        root_reg <= root_next;
        num_reg  <= num_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `GIC_ASSERT_NEXT(a_busy_after_request, clk, rst_n, in_valid && in_ready, !in_ready)
    `GIC_ASSERT_IMPLIES(a_events_exclusive, clk, rst_n, out_valid, !(out_data.connect_event && out_data.disconnect_event))
    `GIC_ASSERT_IMPLIES(a_press_release_exclusive, clk, rst_n, out_valid, (out_data.buttons_pressed & out_data.buttons_released) == 16'h0)
    `GIC_ASSERT_IMPLIES(a_unused_buttons_clear, clk, rst_n, out_valid, (out_data.buttons_held & ~BUTTON_USED_MASK) == 16'h0)

endmodule
